### rtl/core/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain condition checked at every edge out of reset
`define SLIP_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define SLIP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/core/slip_pkg.sv
// Shared types and constants for the segmented load-image parser.
// No dependencies.
`timescale 1ns / 1ps

package slip_pkg;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_START = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	localparam logic [7:0] SIG_NARROW = 8'h5A;  // 'Z', 24-bit fields
	localparam logic [7:0] SIG_WIDE   = 8'h7A;  // 'z', 32-bit fields

	typedef struct packed {
		logic       file_begin;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] target_address;
		logic [7:0]  write_byte;
	} result_t;

endpackage

### rtl/core/slip_parse.sv
// Parser state and per-byte step logic of the load-image parser.
// Depends on slip_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module slip_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  slip_pkg::item_t  item,
	output slip_pkg::result_t result
);
	import slip_pkg::*;

	`include "assert_macros.svh"

	logic        await_q, wide_q, failed_q, in_data_q;
	logic [2:0]  pos_q;
	logic [31:0] addr_q, len_q, remain_q, wr_addr_q;

	logic        await_d, wide_d, failed_d, in_data_d;
	logic [2:0]  pos_d;
	logic [31:0] addr_d, len_d, remain_d, wr_addr_d;

	logic [2:0]  fld;
	logic [2:0]  len_idx;
	logic        in_addr;
	logic [1:0]  lane;
	logic [31:0] cur, merged;

	always_comb begin
		fld     = wide_q ? 3'd4 : 3'd3;
		in_addr = pos_q < fld;
		len_idx = pos_q - fld;
		lane    = in_addr ? pos_q[1:0] : len_idx[1:0];
		cur     = in_addr ? addr_q : len_q;
		// lane 0 starts a fresh field, later lanes fill in above it
		merged  = ((lane == 2'd0) ? 32'd0 : cur) | ({24'd0, item.data_byte} << {lane, 3'b000});
	end

	always_comb begin
		await_d   = await_q;
		wide_d    = wide_q;
		failed_d  = failed_q;
		in_data_d = in_data_q;
		pos_d     = pos_q;
		addr_d    = addr_q;
		len_d     = len_q;
		remain_d  = remain_q;
		wr_addr_d = wr_addr_q;
		result    = '{kind: KIND_NONE, target_address: 32'd0, write_byte: 8'd0};

		if (item.file_begin || await_q) begin
			await_d   = 1'b0;
			pos_d     = 3'd0;
			in_data_d = 1'b0;
			if (item.data_byte == SIG_NARROW) begin
				wide_d   = 1'b0;
				failed_d = 1'b0;
			end else if (item.data_byte == SIG_WIDE) begin
				wide_d   = 1'b1;
				failed_d = 1'b0;
			end else begin
				failed_d    = 1'b1;
				result.kind = KIND_BAD;
			end
		end else if (!failed_q) begin
			if (in_data_q) begin
				result    = '{kind: KIND_WRITE, target_address: wr_addr_q,
					write_byte: item.data_byte};
				wr_addr_d = wr_addr_q + 32'd1;
				remain_d  = remain_q - 32'd1;
				if (remain_q == 32'd1)
					in_data_d = 1'b0;
			end else if (in_addr) begin
				addr_d = merged;
				pos_d  = pos_q + 3'd1;
			end else begin
				len_d = merged;
				if (len_idx == fld - 3'd1) begin
					pos_d = 3'd0;
					if (merged == 32'd0) begin
						result.kind           = KIND_START;
						result.target_address = addr_q;
					end else begin
						in_data_d = 1'b1;
						remain_d  = merged;
						wr_addr_d = addr_q;
					end
				end else begin
					pos_d = pos_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q   <= 1'b1;
			wide_q    <= 1'b0;
			failed_q  <= 1'b0;
			in_data_q <= 1'b0;
			pos_q     <= 3'd0;
		end else if (step) begin
			await_q   <= await_d;
			wide_q    <= wide_d;
			failed_q  <= failed_d;
			in_data_q <= in_data_d;
			pos_q     <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			addr_q    <= addr_d;
			len_q     <= len_d;
			remain_q  <= remain_d;
			wr_addr_q <= wr_addr_d;
		end
	end

	`SLIP_ASSERT_IMP(a_data_pos_zero, in_data_q, pos_q == 3'd0, "data phase with header position set")
	`SLIP_ASSERT_IMP(a_remain_nonzero, in_data_q, remain_q != 32'd0, "data phase with no bytes left")
	`SLIP_ASSERT_IMP(a_narrow_pos, !wide_q, pos_q < 3'd6, "header position past narrow header")

endmodule

### rtl/core/segmented_load_image_parser_core.sv
// Top level of the segmented load-image parser: stream ports, input and result registers.
// Depends on slip_pkg, slip_parse and assert_macros.svh.
`timescale 1ns / 1ps

// Takes a load-image file one byte per word and gives one result word per byte: nothing,
// a memory write (address, byte), the start address of a zero-length segment, or a bad
// signature. A new word is taken every cycle while the result side keeps up; each byte
// passes through the input register and then the single-pass parse step into the result
// register. s_tready follows m_tready in the same cycle when both registers are full.
module segmented_load_image_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] file_begin
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] target_address, [39:32] write_byte
	output logic [1:0]  m_tuser    // [1:0] result_kind
);
	import slip_pkg::*;

	`include "assert_macros.svh"

	logic    valid_s1, valid_s2;
	item_t   item_s1;
	result_t res_s2;
	result_t result;
	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= '{file_begin: s_tuser, data_byte: s_tdata};
		if (advance)
			res_s2 <= result;
	end

	slip_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.write_byte, res_s2.target_address};
	assign m_tuser  = res_s2.kind;

	`SLIP_ASSERT_IMP(a_bad_empty, m_tvalid && m_tuser == KIND_BAD, m_tdata == 40'd0, "bad signature word carries data")
	`SLIP_ASSERT_IMP(a_start_nobyte, m_tvalid && m_tuser == KIND_START, m_tdata[39:32] == 8'd0, "start word carries a byte")

endmodule
